@@ rtl/assert_macros.svh @@
// Assertion macros used by the parser core psp_back.
// The module that uses them provides clk and the active-low reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/psp_pkg.sv @@
// Types and constants shared by the PPM stream parser modules.
// No dependencies.
`timescale 1ns / 1ps

package psp_pkg;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_FORMAT = 3'd0,
        PH_WIDTH  = 3'd1,
        PH_HEIGHT = 3'd2,
        PH_MAXVAL = 3'd3,
        PH_DATA   = 3'd4,
        PH_ERROR  = 3'd5
    } psp_phase_t;

    // Result kinds as seen on the output tuser.
    typedef enum logic [2:0] {
        KIND_FORMAT = 3'd0,
        KIND_WIDTH  = 3'd1,
        KIND_HEIGHT = 3'd2,
        KIND_MAXVAL = 3'd3,
        KIND_SAMPLE = 3'd4,
        KIND_ERROR  = 3'd5
    } psp_kind_t;

    // Character codes.
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Accepted format tokens, first character in the upper byte.
    localparam logic [15:0] FMT_P3 = 16'h5033;
    localparam logic [15:0] FMT_P6 = 16'h5036;

    // Format values reported for each format.
    localparam logic [15:0] FMT_VALUE_P3 = 16'd3;
    localparam logic [15:0] FMT_VALUE_P6 = 16'd6;

    // Decoupling queue between the classifier and the parser.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // One classified input byte.
    typedef struct packed {
        logic [7:0] data;
        logic [3:0] digit;
        logic       is_digit;
        logic       is_sep;
        logic       is_hash;
        logic       is_lf;
        logic       eof;
    } psp_word_t;

endpackage

@@ rtl/psp_front.sv @@
// Input stage of the PPM stream parser: accepts bytes and classifies them.
// Depends on psp_pkg.
`timescale 1ns / 1ps

module psp_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_data,
    input  logic              in_last,
    output logic              word_valid,
    input  logic              word_ready,
    output psp_pkg::psp_word_t word
);
    import psp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    psp_word_t word_reg;
    psp_word_t word_next;

    // Take a new byte whenever the held word is empty or moves on this cycle.
    assign in_ready   = !valid_reg || word_ready;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    // Classify the incoming byte.
    always_comb
    begin
        word_next.data     = in_data;
        word_next.digit    = 4'(in_data - CH_ZERO);
        word_next.is_digit = (in_data >= CH_ZERO) && (in_data <= CH_NINE);
        word_next.is_sep   = (in_data == CH_SPACE) || (in_data == CH_LF)
                             || (in_data == CH_CR);
        word_next.is_hash  = (in_data == CH_HASH);
        word_next.is_lf    = (in_data == CH_LF);
        word_next.eof      = in_last;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (word_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // The payload register needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

endmodule

@@ rtl/psp_queue.sv @@
// Short queue of classified words between the classifier and the parser.
// Depends on psp_pkg.
`timescale 1ns / 1ps

module psp_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  psp_pkg::psp_word_t push_word,
    output logic              pop_valid,
    input  logic              pop_ready,
    output psp_pkg::psp_word_t pop_word
);
    import psp_pkg::*;

    psp_word_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg;
    logic [QUEUE_CNT_W-1:0]   count_next;
    logic                     push;
    logic                     pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

@@ rtl/psp_back.sv @@
// Parser core of the PPM stream parser: header tokens, format check and
// image samples, with the output register. Depends on psp_pkg and
// assert_macros.svh.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module psp_back
#(
    parameter int HEADER_VALUE_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              word_valid,
    output logic              word_ready,
    input  psp_pkg::psp_word_t word,
    output logic              res_valid,
    input  logic              res_ready,
    output psp_pkg::psp_kind_t res_kind,
    output logic [15:0]       res_value,
    output logic              res_last
);
    import psp_pkg::*;

    // Header numbers never exceed 16 bits; the accumulator width follows.
    localparam int ACC_W = (HEADER_VALUE_BITS < 16) ? HEADER_VALUE_BITS : 16;
    localparam int WIDE_W = ACC_W + 4;
    localparam logic [WIDE_W-1:0] HDR_LIMIT = {4'b0, {ACC_W{1'b1}}};

    psp_phase_t         phase_reg, phase_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               open_reg, open_next;
    logic               comment_reg, comment_next;
    logic [15:0]        chars_reg, chars_next;
    logic [1:0]         len_reg, len_next;
    logic               ascii_reg, ascii_next;
    logic               stopped_reg, stopped_next;

    logic               out_valid_reg, out_valid_next;
    psp_kind_t          out_kind_reg;
    logic [15:0]        out_value_reg;
    logic               out_last_reg;

    logic               pop;
    logic               do_close;
    logic               emit;
    psp_kind_t          emit_kind;
    logic [15:0]        emit_value;
    logic [WIDE_W-1:0]  acc_x10;

    assign word_ready = !out_valid_reg || res_ready;
    assign pop        = word_valid && word_ready;

    // Multiply-by-ten accumulate with the new digit.
    assign acc_x10 = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                     + WIDE_W'(word.digit);

    // Per-word parsing step.
    always_comb
    begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        open_next    = open_reg;
        comment_next = comment_reg;
        chars_next   = chars_reg;
        len_next     = len_reg;
        ascii_next   = ascii_reg;
        stopped_next = stopped_reg;
        do_close     = 1'b0;
        emit         = 1'b0;
        emit_kind    = KIND_SAMPLE;
        emit_value   = 16'd0;

        if (pop)
        begin
            if (phase_reg == PH_ERROR)
            begin
                // Everything up to the end of the file is dropped.
            end
            else if (phase_reg == PH_DATA)
            begin
                if (!ascii_reg)
                begin
                    emit       = 1'b1;
                    emit_value = {8'd0, word.data};
                end
                else if (word.is_digit)
                begin
                    acc_next  = ACC_W'(acc_x10);
                    open_next = 1'b1;
                    if (word.eof)
                    begin
                        emit       = 1'b1;
                        emit_value = {8'd0, acc_x10[7:0]};
                    end
                end
                else if (open_reg)
                begin
                    emit       = 1'b1;
                    emit_value = {8'd0, acc_reg[7:0]};
                    open_next  = 1'b0;
                    acc_next   = '0;
                end
            end
            else if (comment_reg)
            begin
                if (word.is_lf)
                begin
                    comment_next = 1'b0;
                end
            end
            else if (word.is_hash)
            begin
                comment_next = 1'b1;
                do_close     = open_reg;
            end
            else if (word.is_sep)
            begin
                do_close = open_reg;
            end
            else
            begin
                open_next = 1'b1;
                if (phase_reg == PH_FORMAT)
                begin
                    chars_next = {chars_reg[7:0], word.data};
                    if (len_reg != 2'd3)
                    begin
                        len_next = len_reg + 2'd1;
                    end
                end
                else if (!stopped_reg && word.is_digit)
                begin
                    acc_next = (acc_x10 > HDR_LIMIT) ? ACC_W'(HDR_LIMIT)
                               : ACC_W'(acc_x10);
                end
                else
                begin
                    stopped_next = 1'b1;
                end
                do_close = word.eof;
            end

            // Close the open header token with the values updated above.
            if (do_close)
            begin
                emit = 1'b1;
                unique case (phase_reg)
                    PH_FORMAT:
                    begin
                        if (len_next == 2'd2 && chars_next == FMT_P3)
                        begin
                            ascii_next = 1'b1;
                            phase_next = PH_WIDTH;
                            emit_kind  = KIND_FORMAT;
                            emit_value = FMT_VALUE_P3;
                        end
                        else if (len_next == 2'd2 && chars_next == FMT_P6)
                        begin
                            ascii_next = 1'b0;
                            phase_next = PH_WIDTH;
                            emit_kind  = KIND_FORMAT;
                            emit_value = FMT_VALUE_P6;
                        end
                        else
                        begin
                            phase_next = PH_ERROR;
                            emit_kind  = KIND_ERROR;
                            emit_value = 16'd0;
                        end
                    end
                    PH_WIDTH:
                    begin
                        phase_next = PH_HEIGHT;
                        emit_kind  = KIND_WIDTH;
                        emit_value = 16'(acc_next);
                    end
                    PH_HEIGHT:
                    begin
                        phase_next = PH_MAXVAL;
                        emit_kind  = KIND_HEIGHT;
                        emit_value = 16'(acc_next);
                    end
                    PH_MAXVAL:
                    begin
                        phase_next = PH_DATA;
                        emit_kind  = KIND_MAXVAL;
                        emit_value = 16'(acc_next);
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
                open_next    = 1'b0;
                acc_next     = '0;
                stopped_next = 1'b0;
                chars_next   = '0;
                len_next     = '0;
            end

            // The last byte of a file brings the parser back to its start.
            if (word.eof)
            begin
                phase_next   = PH_FORMAT;
                acc_next     = '0;
                open_next    = 1'b0;
                comment_next = 1'b0;
                chars_next   = '0;
                len_next     = '0;
                ascii_next   = 1'b0;
                stopped_next = 1'b0;
            end
        end
    end

    // Output register: loaded when a popped word emits a result, drained by the sink.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = emit;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FORMAT;
            acc_reg       <= '0;
            open_reg      <= 1'b0;
            comment_reg   <= 1'b0;
            chars_reg     <= '0;
            len_reg       <= '0;
            ascii_reg     <= 1'b0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            open_reg      <= open_next;
            comment_reg   <= comment_next;
            chars_reg     <= chars_next;
            len_reg       <= len_next;
            ascii_reg     <= ascii_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_kind_reg  <= emit_kind;
            out_value_reg <= emit_value;
            out_last_reg  <= word.eof;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_kind  = out_kind_reg;
    assign res_value = out_value_reg;
    assign res_last  = out_last_reg;

    // A word is never taken while a result is stalled at the output.
    `PSP_ASSERT_SAME(a_no_overwrite, pop, !(out_valid_reg && !res_ready), "result overwritten")
    // The final byte of a file always leaves the parser at its start.
    `PSP_ASSERT_NEXT(a_eof_restart, pop && word.eof, phase_reg == PH_FORMAT && !open_reg, "no restart after end of file")
    // Nothing is emitted for bytes that follow a bad format.
    `PSP_ASSERT_SAME(a_error_quiet, pop && phase_reg == PH_ERROR, !emit, "output after format error")

endmodule

@@ rtl/ppm_stream_parser.sv @@
// Top level of the PPM stream parser.
// Depends on psp_pkg, psp_front, psp_queue and psp_back.
`timescale 1ns / 1ps

// Parses a P3 or P6 PPM file fed one byte per word on the input stream and
// reports the format, width, height and maxval, then one sample per image
// value. tuser carries the kind of each result (0 format, 1 width, 2 height,
// 3 maxval, 4 sample, 5 format error); tlast marks the result caused by the
// byte that carried tlast on the input, after which the parser expects a new
// file. The block takes one byte every clock cycle while m_tready stays high;
// each byte passes the input register, the two-entry queue and the output
// register before its result leaves. Header values saturate at
// 2^HEADER_VALUE_BITS - 1 and at most 65535.
module ppm_stream_parser
#(
    parameter int HEADER_VALUE_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] value
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast
);
    import psp_pkg::*;

    logic      front_valid;
    logic      front_ready;
    psp_word_t front_word;
    logic      queue_valid;
    logic      queue_ready;
    psp_word_t queue_word;
    psp_kind_t res_kind;

    // Byte intake and classification.
    psp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .in_last    (s_tlast),
        .word_valid (front_valid),
        .word_ready (front_ready),
        .word       (front_word)
    );

    // Decoupling queue.
    psp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_word  (front_word),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_word   (queue_word)
    );

    // Parser core and output register.
    psp_back
    #(
        .HEADER_VALUE_BITS (HEADER_VALUE_BITS)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (queue_valid),
        .word_ready (queue_ready),
        .word       (queue_word),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_kind   (res_kind),
        .res_value  (m_tdata),
        .res_last   (m_tlast)
    );

    assign m_tuser = res_kind;

endmodule
